// File: rtl/core/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared codes, register indexes and types for the button click detector.
// ----------------------------------------------------------------------------
package bcd_pkg;

	localparam int unsigned CFG_IDX_W = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd2;

	localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [15:0] CLICK_GAP_RST  = 16'd400;
	localparam logic [15:0] LONG_PRESS_RST = 16'd800;

	// Gesture modes.
	localparam logic [2:0] M_IDLE     = 3'd0;
	localparam logic [2:0] M_DOWN     = 3'd1;
	localparam logic [2:0] M_UP       = 3'd2;
	localparam logic [2:0] M_COUNT    = 3'd3;
	localparam logic [2:0] M_HELD     = 3'd4;
	localparam logic [2:0] M_HELD_END = 3'd5;

	// Event codes.
	localparam logic [2:0] EV_NONE       = 3'd0;
	localparam logic [2:0] EV_CLICK      = 3'd1;
	localparam logic [2:0] EV_DOUBLE     = 3'd2;
	localparam logic [2:0] EV_LONG_START = 3'd3;
	localparam logic [2:0] EV_LONG_STOP  = 3'd4;

	localparam logic [7:0] CLICK_MAX    = 8'd255;
	localparam logic [7:0] DOUBLE_COUNT = 8'd2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [2:0]  prior_mode;
		logic [31:0] change_time;
		logic [7:0]  click_count;
	} bcd_state_t;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] click_gap_ms;
		logic [15:0] long_press_ms;
	} bcd_cfg_t;

endpackage

// File: rtl/core/bcd_step.sv
// ----------------------------------------------------------------------------
// bcd_step
// Next-state and event logic of the gesture machine for one button sample.
// ----------------------------------------------------------------------------
module bcd_step import bcd_pkg::*; (
	input  bcd_state_t  cur,
	input  bcd_cfg_t    cfg,
	input  logic        pressed,
	input  logic [31:0] now_ms,
	output bcd_state_t  nxt,
	output logic [2:0]  ev
);

	logic [31:0] elapsed;
	logic        lt_debounce;
	logic        gt_long;
	logic        gt_gap;

	// Wrap-around difference, so the millisecond counter may roll over.
	assign elapsed     = now_ms - cur.change_time;
	assign lt_debounce = elapsed < {16'd0, cfg.debounce_ms};
	assign gt_long     = elapsed > {16'd0, cfg.long_press_ms};
	assign gt_gap      = elapsed > {16'd0, cfg.click_gap_ms};

	always_comb begin
		nxt = cur;
		ev  = EV_NONE;
		unique case (cur.mode)
			M_IDLE: begin
				if (pressed) begin
					nxt.prior_mode  = cur.mode;
					nxt.mode        = M_DOWN;
					nxt.change_time = now_ms;
					nxt.click_count = 8'd0;
				end
			end
			M_DOWN: begin
				if (!pressed && lt_debounce) begin
					nxt.prior_mode = cur.mode;
					nxt.mode       = cur.prior_mode;
				end else if (!pressed) begin
					nxt.prior_mode  = cur.mode;
					nxt.mode        = M_UP;
					nxt.change_time = now_ms;
				end else if (gt_long) begin
					ev             = EV_LONG_START;
					nxt.prior_mode = cur.mode;
					nxt.mode       = M_HELD;
				end
			end
			M_UP: begin
				if (pressed && lt_debounce) begin
					nxt.prior_mode = cur.mode;
					nxt.mode       = cur.prior_mode;
				end else if (!lt_debounce) begin
					if (cur.click_count != CLICK_MAX) begin
						nxt.click_count = cur.click_count + 8'd1;
					end
					nxt.prior_mode = cur.mode;
					nxt.mode       = M_COUNT;
				end
			end
			M_COUNT: begin
				if (pressed) begin
					nxt.prior_mode  = cur.mode;
					nxt.mode        = M_DOWN;
					nxt.change_time = now_ms;
				end else if (gt_gap || cur.click_count == DOUBLE_COUNT) begin
					ev  = (cur.click_count == 8'd1) ? EV_CLICK : EV_DOUBLE;
					nxt = '0;
				end
			end
			M_HELD: begin
				if (!pressed) begin
					nxt.prior_mode  = cur.mode;
					nxt.mode        = M_HELD_END;
					nxt.change_time = now_ms;
				end
			end
			M_HELD_END: begin
				if (pressed && lt_debounce) begin
					nxt.prior_mode = cur.mode;
					nxt.mode       = cur.prior_mode;
				end else if (!lt_debounce) begin
					ev  = EV_LONG_STOP;
					nxt = '0;
				end
			end
			default: begin
				// Unused mode codes fall back to idle without an event.
				nxt.prior_mode = cur.mode;
				nxt.mode       = M_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/button_click_detector.sv
// ----------------------------------------------------------------------------
// button_click_detector
// Turns timestamped button samples into click, double click and long-press
// events, one event code per sample.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   input     in_valid / in_stall  pressed, now_ms
//   output    out_valid/ out_stall event_res
//   config    cfg_valid/ cfg_ready cfg_index, cfg_data (always ready)
//
// A sample is registered on acceptance and its event is registered in the
// output register as the sample advances; one sample is taken every cycle
// while the input is not stalled. The gesture state updates as a sample
// moves into the output register. The input stalls only while the input
// register is full and the output register holds a stalled event. Reset
// puts the machine in idle and loads the default timing registers.
// ----------------------------------------------------------------------------
module button_click_detector import bcd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 pressed,
	input  logic [31:0]          now_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           event_res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	bcd_cfg_t    cfg_q;
	bcd_state_t  state_q;
	bcd_state_t  state_nxt;
	logic        valid_s1;
	logic        pressed_s1;
	logic [31:0] now_s1;
	logic        out_valid_q;
	logic [2:0]  event_q;
	logic [2:0]  ev_nxt;
	logic        advance;
	logic        in_take;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign event_res = event_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.click_gap_ms  <= CLICK_GAP_RST;
			cfg_q.long_press_ms <= LONG_PRESS_RST;
		end else if (cfg_valid && cfg_ready) begin
			// Writes to an index beyond the register list are dropped.
			unique case (cfg_index)
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_data;
				REG_CLICK_GAP:  cfg_q.click_gap_ms  <= cfg_data;
				REG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pressed_s1 <= pressed;
			now_s1     <= now_ms;
		end
	end

	bcd_step u_step (
		.cur     (state_q),
		.cfg     (cfg_q),
		.pressed (pressed_s1),
		.now_ms  (now_s1),
		.nxt     (state_nxt),
		.ev      (ev_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= ev_nxt;
		end
	end

endmodule

// File: sim/button_click_detector_tb.sv
// ----------------------------------------------------------------------------
// button_click_detector_tb
// Self-checking bench for the button click detector. A directed table walks
// clicks, double clicks, long presses, bounces and time wrap-around. Random
// gestures then run under several timing settings, including the extremes,
// with random gaps on the sample channel and random stalls on the event
// channel. Every event is compared against an in-bench model of the gesture
// state machine, or against the expected event of a typed table entry.
// ----------------------------------------------------------------------------
module button_click_detector_tb;
	import bcd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned SAT_CLICKS = 256;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic        down;
		logic [31:0] at;
		logic        typed;
		logic [2:0]  ev;
	} probe_t;

	localparam int PROBE_N = 27;
	localparam probe_t PROBES [PROBE_N] = '{
		'{1'b0, 32'd0,          1'b1, EV_NONE},
		'{1'b1, 32'd1000,       1'b0, EV_NONE},
		'{1'b1, 32'd1500,       1'b0, EV_NONE},
		'{1'b0, 32'd1600,       1'b0, EV_NONE},
		'{1'b0, 32'd1660,       1'b0, EV_NONE},
		'{1'b0, 32'd2061,       1'b1, EV_CLICK},
		'{1'b1, 32'd3000,       1'b0, EV_NONE},
		'{1'b0, 32'd3100,       1'b0, EV_NONE},
		'{1'b0, 32'd3200,       1'b0, EV_NONE},
		'{1'b1, 32'd3300,       1'b0, EV_NONE},
		'{1'b0, 32'd3400,       1'b0, EV_NONE},
		'{1'b0, 32'd3500,       1'b0, EV_NONE},
		'{1'b0, 32'd3501,       1'b1, EV_DOUBLE},
		'{1'b1, 32'd5000,       1'b0, EV_NONE},
		'{1'b1, 32'd5801,       1'b1, EV_LONG_START},
		'{1'b0, 32'd6000,       1'b0, EV_NONE},
		'{1'b0, 32'd6050,       1'b1, EV_LONG_STOP},
		'{1'b1, 32'd7000,       1'b0, EV_NONE},
		'{1'b0, 32'd7049,       1'b0, EV_NONE},
		'{1'b1, 32'hFFFF_FFF0,  1'b0, EV_NONE},
		'{1'b0, 32'h0000_0040,  1'b0, EV_NONE},
		'{1'b1, 32'h0000_0050,  1'b0, EV_NONE},
		'{1'b1, 32'hFFFF_FFFF,  1'b1, EV_LONG_START},
		'{1'b0, 32'hFFFF_FFFF,  1'b0, EV_NONE},
		'{1'b1, 32'h0000_0010,  1'b0, EV_NONE},
		'{1'b0, 32'h0000_0020,  1'b0, EV_NONE},
		'{1'b0, 32'h0000_0060,  1'b1, EV_LONG_STOP}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 pressed = 1'b0;
	logic [31:0]          now_ms = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [2:0]           event_res;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	button_click_detector i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pressed   (pressed),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_res (event_res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model of the gesture machine and its timing registers.
	bcd_state_t gesture_st = '0;
	bcd_cfg_t   timing = '{DEBOUNCE_RST, CLICK_GAP_RST, LONG_PRESS_RST};

	logic [2:0]  pending_events [$];
	logic [31:0] t_cur = '0;
	logic [2:0]  got_ev;
	int unsigned idle_pct = 27;
	int unsigned quiet_cycles = 0;
	int unsigned n_sent = 0;
	int unsigned n_cfg = 0;
	int unsigned n_err = 0;
	int unsigned ev_seen [5] = '{0, 0, 0, 0, 0};

	function automatic void enter_mode(input logic [2:0] nxt);
		gesture_st.prior_mode = gesture_st.mode;
		gesture_st.mode = nxt;
	endfunction

	function automatic void end_gesture();
		gesture_st = '0;
	endfunction

	function automatic logic [2:0] gesture_event(input logic down, input logic [31:0] t);
		logic [31:0] elapsed;
		logic [2:0]  ev;
		elapsed = t - gesture_st.change_time;
		ev = EV_NONE;
		case (gesture_st.mode)
			M_IDLE: begin
				if (down) begin
					enter_mode(M_DOWN);
					gesture_st.change_time = t;
					gesture_st.click_count = '0;
				end
			end
			M_DOWN: begin
				if (!down && elapsed < timing.debounce_ms) begin
					enter_mode(gesture_st.prior_mode);
				end else if (!down) begin
					enter_mode(M_UP);
					gesture_st.change_time = t;
				end else if (elapsed > timing.long_press_ms) begin
					ev = EV_LONG_START;
					enter_mode(M_HELD);
				end
			end
			M_UP: begin
				if (down && elapsed < timing.debounce_ms) begin
					enter_mode(gesture_st.prior_mode);
				end else if (elapsed >= timing.debounce_ms) begin
					if (gesture_st.click_count < CLICK_MAX)
						gesture_st.click_count = gesture_st.click_count + 8'd1;
					enter_mode(M_COUNT);
				end
			end
			M_COUNT: begin
				if (down) begin
					enter_mode(M_DOWN);
					gesture_st.change_time = t;
				end else if (elapsed > timing.click_gap_ms ||
						gesture_st.click_count == DOUBLE_COUNT) begin
					ev = (gesture_st.click_count == 8'd1) ? EV_CLICK : EV_DOUBLE;
					end_gesture();
				end
			end
			M_HELD: begin
				if (!down) begin
					enter_mode(M_HELD_END);
					gesture_st.change_time = t;
				end
			end
			M_HELD_END: begin
				if (down && elapsed < timing.debounce_ms) begin
					enter_mode(gesture_st.prior_mode);
				end else if (elapsed >= timing.debounce_ms) begin
					ev = EV_LONG_STOP;
					end_gesture();
				end
			end
			default: begin
				enter_mode(M_IDLE);
			end
		endcase
		return ev;
	endfunction

	// One sample transfer, with a random gap in front of it.
	task automatic send(input logic down, input logic [31:0] t, input logic typed,
			input logic [2:0] typed_ev);
		logic [2:0] ev;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			pressed <= 1'($urandom);
			now_ms <= $urandom;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pressed <= down;
		now_ms <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		ev = gesture_event(down, t);
		pending_events.push_back(typed ? typed_ev : ev);
		n_sent++;
	endtask

	task automatic advance(input logic down, input int unsigned dt);
		t_cur = t_cur + dt;
		send(down, t_cur, 1'b0, EV_NONE);
	endtask

	task automatic wait_for_events();
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_DEBOUNCE:   timing.debounce_ms = val;
			REG_CLICK_GAP:  timing.click_gap_ms = val;
			REG_LONG_PRESS: timing.long_press_ms = val;
			default: ;
		endcase
		n_cfg++;
	endtask

	// Timing changes only with the machine drained; the unused index is
	// written too and must have no effect.
	task automatic configure(input logic [15:0] deb, input logic [15:0] gap,
			input logic [15:0] lng);
		wait_for_events();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_CLICK_GAP, gap);
		write_reg(REG_LONG_PRESS, lng);
		write_reg(REG_UNUSED, 16'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int unsigned near(input int unsigned b);
		return (b == 0) ? $urandom_range(1) : b - 1 + $urandom_range(2);
	endfunction

	task automatic tap(input int unsigned deb, input int unsigned lng);
		advance(1'b1, $urandom_range(5));
		repeat ($urandom_range(2)) advance(1'b1, $urandom_range(lng / 2));
		advance(1'b0, near(deb));
		advance(1'b0, near(deb));
	endtask

	task automatic play_gesture();
		int unsigned deb, gap, lng, kind, dt;
		deb = timing.debounce_ms;
		gap = timing.click_gap_ms;
		lng = timing.long_press_ms;
		kind = $urandom_range(99);
		// A quiet lead-in lets any earlier click be decided.
		if (kind < 80) advance(1'b0, gap + 1 + $urandom_range(20));
		if (kind < 25) begin
			tap(deb, lng);
			advance(1'b0, gap + $urandom_range(2));
		end else if (kind < 45) begin
			tap(deb, lng);
			tap(deb, lng);
			advance(1'b0, 1);
		end else if (kind < 65) begin
			advance(1'b1, $urandom_range(5));
			advance(1'b1, lng + $urandom_range(2));
			advance(1'b1, $urandom_range(50, 1));
			advance(1'b0, $urandom_range(20));
			if ($urandom_range(1)) begin
				advance(1'b1, $urandom_range(deb));
				advance(1'b0, $urandom_range(10));
			end
			advance(1'b0, near(deb));
			advance(1'b0, near(deb));
		end else if (kind < 80) begin
			advance(1'b1, $urandom_range(5));
			advance(1'b0, $urandom_range(deb));
		end else begin
			repeat ($urandom_range(8, 3)) begin
				case ($urandom_range(3))
					0: dt = $urandom_range(3);
					1: dt = $urandom_range(2 * (deb + gap + lng) + 2);
					2: dt = $urandom;
					default: dt = near(deb);
				endcase
				if ($urandom_range(9) == 0) begin
					t_cur = $urandom;
					dt = 0;
				end
				advance(1'($urandom), dt);
			end
		end
	endtask

	task automatic run_gestures(input int unsigned n);
		int unsigned target;
		target = n_sent + n;
		while (n_sent < target) play_gesture();
	endtask

	// With all timing at zero, quick re-presses drive the click count into
	// saturation before the double click is finally reported.
	task automatic rapid_clicks(input int unsigned n);
		repeat (4) advance(1'b0, 1);
		advance(1'b1, 1);
		repeat (n) begin
			advance(1'b0, 1);
			advance(1'b1, 1);
			advance(1'b1, 1);
		end
		repeat (3) advance(1'b0, 1);
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				n_err++;
				if (n_err <= MAX_REPORTS)
					$display("event %0d with no sample waiting for it", event_res);
			end else begin
				got_ev = pending_events.pop_front();
				if (event_res !== got_ev) begin
					n_err++;
					if (n_err <= MAX_REPORTS)
						$display("event_res mismatch: expected %0d, got %0d", got_ev,
							event_res);
				end
			end
			if (event_res <= EV_LONG_STOP) ev_seen[event_res]++;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PROBES[i])
			send(PROBES[i].down, PROBES[i].at, PROBES[i].typed, PROBES[i].ev);
		t_cur = PROBES[PROBE_N-1].at;

		run_gestures(30);

		configure(16'd0, 16'd0, 16'd0);
		rapid_clicks(SAT_CLICKS);
		run_gestures(25);

		configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
		t_cur = 32'hFFFF_0000 + $urandom_range(16'hFFFF);
		run_gestures(30);

		configure(16'($urandom_range(80, 1)), 16'($urandom_range(500, 20)),
			16'($urandom_range(1000, 50)));
		idle_pct = 0;
		run_gestures(30);
		idle_pct = 27;

		// Let the event side run dry before sending more.
		wait_for_events();

		configure(16'($urandom_range(80, 1)), 16'($urandom_range(500, 20)),
			16'($urandom_range(1000, 50)));
		run_gestures(30);

		wait_for_events();
		n_err += pending_events.size();

		$display("Covered %0d samples and %0d register writes over five timing settings.",
			n_sent, n_cfg);
		$display("Events seen: none %0d, click %0d, double %0d, long start %0d, long stop %0d.",
			ev_seen[0], ev_seen[1], ev_seen[2], ev_seen[3], ev_seen[4]);
		if (n_err == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches in total", n_err);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/bcd_pkg.sv
rtl/core/bcd_step.sv
rtl/core/button_click_detector.sv
sim/button_click_detector_tb.sv
